/* sv/svprp_pkg.sv */
// ----------------------------------------------------------------------------
// svprp_pkg
// Shared types and constants for the servo position reply parser: frame
// characters, byte slot numbers, status codes and the frame result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package svprp_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdW     = 10;
  localparam int unsigned CfgIdW  = 8;
  localparam int unsigned PosW    = 14;
  localparam int unsigned FillW   = 4;

  // Frame characters
  localparam logic [ByteW-1:0] CharHash = 8'h23;  // '#'
  localparam logic [ByteW-1:0] CharP    = 8'h50;  // 'P'
  localparam logic [ByteW-1:0] CharBang = 8'h21;  // '!'
  localparam logic [ByteW-1:0] CharZero = 8'h30;  // '0'
  localparam logic [ByteW-1:0] CharNine = 8'h39;  // '9'

  // Byte slots within an open frame (fill count before the byte lands)
  localparam logic [FillW-1:0] SlotIdle     = 4'd0;
  localparam logic [FillW-1:0] SlotOpen     = 4'd1;
  localparam logic [FillW-1:0] SlotIdFirst  = 4'd1;
  localparam logic [FillW-1:0] SlotIdLast   = 4'd3;
  localparam logic [FillW-1:0] SlotPosMark  = 4'd4;
  localparam logic [FillW-1:0] SlotPosFirst = 4'd5;
  localparam logic [FillW-1:0] SlotPosLast  = 4'd8;
  localparam logic [FillW-1:0] SlotEnd      = 4'd9;

  // Result status codes
  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusMalformed = 2'd1,
    StatusOtherId   = 2'd2
  } status_e;

  // One completed frame
  typedef struct packed {
    logic               valid;
    status_e            status;
    logic [PosW-1:0]    position;
  } frame_result_t;

endpackage

`default_nettype wire

/* sv/svprp_frame.sv */
// ----------------------------------------------------------------------------
// svprp_frame
// Per-byte frame tracker: holds the fill count, decimal accumulators and
// format flag, and reports a result on the terminating byte of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module svprp_frame (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          byte_valid_i,
  input  wire logic [svprp_pkg::ByteW-1:0]   byte_i,
  input  wire logic [svprp_pkg::CfgIdW-1:0]  expected_id_i,
  output      svprp_pkg::frame_result_t      result_o
);
  import svprp_pkg::*;

  logic [FillW-1:0] fill_q, fill_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             good_q, good_d;

  logic             is_hash;
  logic             is_digit;
  logic [3:0]       digit;
  logic [IdW-1:0]   id_next;
  logic [PosW-1:0]  pos_next;
  logic             good_end;

  // Classify the incoming byte
  assign is_hash  = (byte_i == CharHash);
  assign is_digit = (byte_i >= CharZero) && (byte_i <= CharNine);
  assign digit    = byte_i[3:0];

  // Decimal accumulate: x*10 + d as two shifts and adds
  assign id_next  = (id_q << 3) + (id_q << 1) + IdW'(digit);
  assign pos_next = (pos_q << 3) + (pos_q << 1) + PosW'(digit);

  // Terminator check on the final slot
  assign good_end = good_q && (byte_i == CharBang);

  // Advance the frame state for one accepted item
  always_comb begin
    fill_d   = fill_q;
    id_d     = id_q;
    pos_d    = pos_q;
    good_d   = good_q;
    result_o = '{valid: 1'b0, status: StatusOk, position: '0};
    if (byte_valid_i) begin
      if (is_hash) begin
        fill_d = SlotOpen;
        id_d   = '0;
        pos_d  = '0;
        good_d = 1'b1;
      end else if (fill_q != SlotIdle) begin
        fill_d = fill_q + 4'd1;
        unique case (fill_q) inside
          [SlotIdFirst:SlotIdLast]: begin
            if (is_digit) id_d = id_next;
            else          good_d = 1'b0;
          end
          SlotPosMark: begin
            if (byte_i != CharP) good_d = 1'b0;
          end
          [SlotPosFirst:SlotPosLast]: begin
            if (is_digit) pos_d = pos_next;
            else          good_d = 1'b0;
          end
          default: begin
            // terminator slot: close the frame and report
            fill_d          = SlotIdle;
            good_d          = good_end;
            result_o.valid  = 1'b1;
            if (!good_end) begin
              result_o.status = StatusMalformed;
            end else if (id_q != IdW'(expected_id_i)) begin
              result_o.status = StatusOtherId;
            end else begin
              result_o.status   = StatusOk;
              result_o.position = pos_q;
            end
          end
        endcase
      end
    end
  end

  // Hold the frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= SlotIdle;
      id_q   <= '0;
      pos_q  <= '0;
      good_q <= 1'b1;
    end else begin
      fill_q <= fill_d;
      id_q   <= id_d;
      pos_q  <= pos_d;
      good_q <= good_d;
    end
  end

  // The fill count never runs past the terminator slot
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= SlotEnd)
    else $error("fill count out of range");

  // A result only comes from a non-'#' item landing in the terminator slot
  a_result_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (byte_valid_i && !is_hash && fill_q == SlotEnd))
    else $error("result outside terminator slot");

  // After a '#' the frame is open at its first slot
  a_hash_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_valid_i && is_hash) |=> (fill_q == SlotOpen && good_q))
    else $error("'#' did not open a frame");

endmodule

`default_nettype wire

/* sv/servo_position_reply_parser_core.sv */
// Output: a result appears on the master side in the cycle after the item
//   that carries the frame terminator is accepted.
// Throughput: one item per cycle; the result register lets a new item in
//   whenever it is empty or being drained in the same cycle.
// Reset: asynchronous, active low; closes any open frame, empties the result
//   register and sets expected_id to zero.
// ----------------------------------------------------------------------------
// servo_position_reply_parser_core
// Finds ten-byte servo position replies in a received byte stream and
// returns a status for each completed frame, with the decoded position when ok.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_position_reply_parser_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [svprp_pkg::CfgIdW-1:0]  cfg_wdata_i,   // expected_id
  // byte input
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  // result output
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [15:0]                   m_axis_tdata   // [1:0] status, [15:2] position
);
  import svprp_pkg::*;

  logic [CfgIdW-1:0] expected_id_q;
  logic              in_accept;
  logic              out_accept;
  frame_result_t     frame_res;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [PosW-1:0]   out_pos_q;

  // Hold the expected id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= '0;
    end else if (cfg_we_i) begin
      expected_id_q <= cfg_wdata_i;
    end
  end

  // Take an item when the result register is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_accept    = out_valid_q && m_axis_tready;

  svprp_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (in_accept),
    .byte_i        (s_axis_tdata[ByteW-1:0]),
    .expected_id_i (expected_id_q),
    .result_o      (frame_res)
  );

  // Result register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (frame_res.valid)  out_valid_d = 1'b1;
    else if (out_accept)  out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (frame_res.valid) begin
      out_status_q <= frame_res.status;
      out_pos_q    <= frame_res.position;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pos_q, out_status_q};

  // A pending result that is not taken blocks the input side
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while result stalled");

  // Position is zero for any status other than ok
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != StatusOk) |-> (out_pos_q == '0))
    else $error("nonzero position on failed frame");

  // A new frame result always lands in the result register
  a_result_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_res.valid |=> out_valid_q)
    else $error("frame result lost");

endmodule

`default_nettype wire
